/* sv/qtpd_pkg.sv */
// ============================================================================
// Quadrature tone power detector package
// Shared constants, command and status types, and the reference sine table.
// ============================================================================
`default_nettype none

package qtpd_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int S_TDATA_W    = 16;
    localparam int POWER_W      = 27;
    localparam int M_TDATA_W    = 32;
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int REP_W        = 3;
    localparam int REPEAT_MAX   = 4;
    localparam int PERIOD_RESET = 256;

    localparam int SINE_W       = 8;
    localparam int ADDR_W       = 8;
    localparam int TIDX_W       = 7;
    localparam int PHASE_SHIFT  = 6;
    localparam int QUAD_OFFSET  = 32;
    localparam int SCALE_SHIFT  = 6;

    localparam int MUL_W        = 14;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int PART_W       = 14;
    localparam int POW_W        = 30;
    localparam int DIV_W        = 30;
    localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD_LEN   = 1'b0,
        REG_REPEAT_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_SRC_INDEX   = 2'd0,
        DIV_SRC_INPHASE = 2'd1,
        DIV_SRC_QUAD    = 2'd2,
        DIV_SRC_POWER   = 2'd3
    } div_src_t;

    typedef enum logic [1:0] {
        MUL_SRC_INPHASE = 2'd0,
        MUL_SRC_QUAD    = 2'd1,
        MUL_SRC_RE      = 2'd2,
        MUL_SRC_IM      = 2'd3
    } mul_src_t;

    typedef struct packed {
        logic     load_sample;
        logic     div_start;
        div_src_t div_src;
        logic     latch_t;
        logic     mul_en;
        mul_src_t mul_src;
        logic     acc_inph;
        logic     acc_quad;
        logic     step_index;
        logic     latch_re;
        logic     latch_im;
        logic     acc_power;
        logic     end_block;
        logic     load_result;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_sample;
        logic last_block;
        logic out_free;
    } status_t;

    localparam logic signed [SINE_W-1:0] QUARTER_WAVE [0:32] = '{
        8'sd0,   8'sd6,   8'sd12,  8'sd19,  8'sd25,  8'sd31,  8'sd37,  8'sd43,
        8'sd49,  8'sd54,  8'sd60,  8'sd65,  8'sd71,  8'sd76,  8'sd81,  8'sd85,
        8'sd90,  8'sd94,  8'sd98,  8'sd102, 8'sd106, 8'sd109, 8'sd112, 8'sd115,
        8'sd117, 8'sd120, 8'sd122, 8'sd123, 8'sd125, 8'sd126, 8'sd126, 8'sd127,
        8'sd127
    };

    // One full sine period spans 128 table entries.
    function automatic logic signed [SINE_W-1:0] sine_at(input logic [ADDR_W-1:0] k);
        logic [ADDR_W-1:0]        m;
        logic [5:0]               q;
        logic                     neg;
        logic signed [SINE_W-1:0] v;
        m   = {1'b0, k[6:0]};
        neg = 1'b0;
        if (m <= 8'd32) begin
            q = m[5:0];
        end else if (m <= 8'd64) begin
            q = 6'(8'd64 - m);
        end else if (m <= 8'd96) begin
            q   = 6'(m - 8'd64);
            neg = 1'b1;
        end else begin
            q   = 6'(8'd128 - m);
            neg = 1'b1;
        end
        v = QUARTER_WAVE[q];
        return neg ? -v : v;
    endfunction

endpackage

`default_nettype wire

/* sv/quadrature_tone_power_detector_core.sv */
// ============================================================================
// Quadrature tone power detector core
// Single-bin quadrature correlator that reports averaged tone power.
// ============================================================================
//  Channel   Ports                          Contents
//  input     s_tvalid s_tready s_tdata      sample [11:0]
//  output    m_tvalid m_tready m_tdata      power [26:0]
//  config    cfg_wr_en cfg_index cfg_wr_data period_len (0), repeat_count (1)
//
//  A sample runs the 7-step index divider and then the two products through
//  one shared multiplier.
//  The sample that closes a block adds two 30-step divisions and the two
//  squares; the last block of a result adds one more 30-step division.
//  A waiting result stalls the controller only when the next one is ready.
//  Reset loads period_len 256 and repeat_count 4 and clears all sums.
// ============================================================================
`default_nettype none

module quadrature_tone_power_detector_core #(
    parameter int MAX_PERIOD   = 256,
    parameter int TABLE_POINTS = 160
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [qtpd_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [qtpd_pkg::M_TDATA_W-1:0]    m_tdata,   // [26:0] power
    input  wire logic                              cfg_wr_en,
    input  wire logic [qtpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [qtpd_pkg::CFG_W-1:0]        cfg_wr_data
);
    import qtpd_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [POWER_W-1:0] power;

    qtpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qtpd_datapath #(
        .MAX_PERIOD   (MAX_PERIOD),
        .TABLE_POINTS (TABLE_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .sample_in   (s_tdata[SAMPLE_W-1:0]),
        .cmd         (cmd),
        .status      (status),
        .power       (power),
        .power_valid (m_tvalid),
        .power_ready (m_tready)
    );

    assign m_tdata = {{(M_TDATA_W - POWER_W){1'b0}}, power};

endmodule

`default_nettype wire

/* sv/qtpd_divider.sv */
// ============================================================================
// Quadrature tone power detector divider
// Restoring unsigned divider, one quotient bit per cycle, shared by all uses.
// ============================================================================
`default_nettype none

module qtpd_divider #(
    parameter int PER_W = 9
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [qtpd_pkg::DIV_CNT_W-1:0]   steps,
    input  wire logic [PER_W-1:0]                 rem_init,
    input  wire logic [qtpd_pkg::DIV_W-1:0]       dividend,
    input  wire logic [PER_W-1:0]                 divisor,
    output logic      [qtpd_pkg::DIV_W-1:0]       quotient,
    output logic                                  done
);
    import qtpd_pkg::*;

    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [PER_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [PER_W:0]       shifted;
    logic [PER_W:0]       diff;
    logic                 fits;

    assign shifted  = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign fits     = shifted >= {1'b0, dvs_reg};
    assign rem_next = fits ? diff[PER_W-1:0] : shifted[PER_W-1:0];
    assign quo_next = {quo_reg[DIV_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= rem_init;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

`default_nettype wire

/* sv/qtpd_datapath.sv */
// ============================================================================
// Quadrature tone power detector datapath
// Configuration, correlation sums, shared multiplier, divider and result register.
// ============================================================================
`default_nettype none

module qtpd_datapath #(
    parameter int MAX_PERIOD   = 256,
    parameter int TABLE_POINTS = 160
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [qtpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [qtpd_pkg::CFG_W-1:0]        cfg_wr_data,
    input  wire logic [qtpd_pkg::SAMPLE_W-1:0]     sample_in,
    input  wire qtpd_pkg::cmd_t                    cmd,
    output qtpd_pkg::status_t                      status,
    output logic      [qtpd_pkg::POWER_W-1:0]      power,
    output logic                                   power_valid,
    input  wire logic                              power_ready
);
    import qtpd_pkg::*;

    localparam int IDX_W     = $clog2(2 * MAX_PERIOD);
    localparam int PER_W     = $clog2(MAX_PERIOD + 1);
    localparam int CMP_W     = PER_W + 2;
    localparam int SUM_W     = SAMPLE_W + SINE_W + IDX_W;
    localparam int MAG_W     = SUM_W - SCALE_SHIFT;
    localparam int PERIOD_RST = (PERIOD_RESET > MAX_PERIOD) ? MAX_PERIOD : PERIOD_RESET;

    logic [PER_W-1:0]           period_reg;
    logic [REP_W-1:0]           repeat_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [TIDX_W-1:0]          t_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    inph_reg, quad_reg;
    logic signed [PART_W-1:0]   re_reg, im_reg;
    logic [POW_W-1:0]           power_sum_reg;
    logic [REP_W-1:0]           block_reg;
    logic [POWER_W-1:0]         out_reg;
    logic                       out_valid_reg;

    logic [PER_W-1:0]           period_wr;
    logic [REP_W-1:0]           repeat_wr;
    logic [CFG_W-1:0]           period_even;
    logic                       last_sample;
    logic                       last_block;

    logic [ADDR_W-1:0]          addr_i, addr_q;
    logic signed [SINE_W-1:0]   sine_i, sine_q;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]          prod_bits;

    logic signed [MAG_W-1:0]    inph_sc, quad_sc;
    logic [MAG_W-1:0]           inph_mag, quad_mag;
    logic signed [PART_W-1:0]   div_part;

    logic [DIV_CNT_W-1:0]       div_steps;
    logic [PER_W-1:0]           div_rem_init;
    logic [DIV_W-1:0]           div_dividend;
    logic [PER_W-1:0]           div_divisor;
    logic [DIV_W-1:0]           div_q;
    logic                       div_done;

    always_comb
    begin
        period_even = {cfg_wr_data[CFG_W-1:1], 1'b0};
        if (period_even < CFG_W'(2))
        begin
            period_even = CFG_W'(2);
        end
        if (int'(period_even) > MAX_PERIOD)
        begin
            period_wr = PER_W'(MAX_PERIOD);
        end
        else
        begin
            period_wr = PER_W'(period_even);
        end
        repeat_wr = cfg_wr_data[REP_W-1:0];
        if (repeat_wr == '0)
        begin
            repeat_wr = REP_W'(1);
        end
        else if (repeat_wr > REP_W'(REPEAT_MAX))
        begin
            repeat_wr = REP_W'(REPEAT_MAX);
        end
    end

    assign last_sample = (CMP_W'(idx_reg) + CMP_W'(1)) == CMP_W'({period_reg, 1'b0});
    assign last_block  = (block_reg + REP_W'(1)) >= repeat_reg;
    assign idx_next    = last_sample ? '0 : idx_reg + IDX_W'(1);

    assign addr_i = {1'b0, t_reg};
    assign addr_q = addr_i + ADDR_W'(QUAD_OFFSET);
    assign sine_i = (int'(addr_i) < TABLE_POINTS) ? sine_at(addr_i) : '0;
    assign sine_q = (int'(addr_q) < TABLE_POINTS) ? sine_at(addr_q) : '0;

    always_comb
    begin
        case (cmd.mul_src)
            MUL_SRC_INPHASE:
            begin
                mul_a = MUL_W'(sample_reg);
                mul_b = MUL_W'(sine_i);
            end
            MUL_SRC_QUAD:
            begin
                mul_a = MUL_W'(sample_reg);
                mul_b = MUL_W'(sine_q);
            end
            MUL_SRC_RE:
            begin
                mul_a = MUL_W'(re_reg);
                mul_b = MUL_W'(re_reg);
            end
            MUL_SRC_IM:
            begin
                mul_a = MUL_W'(im_reg);
                mul_b = MUL_W'(im_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_bits = prod_reg;

    // Floor shift by the scale, then divide the magnitude and restore the sign.
    assign inph_sc  = inph_reg[SUM_W-1:SCALE_SHIFT];
    assign quad_sc  = quad_reg[SUM_W-1:SCALE_SHIFT];
    assign inph_mag = inph_sc[MAG_W-1] ? -inph_sc : inph_sc;
    assign quad_mag = quad_sc[MAG_W-1] ? -quad_sc : quad_sc;
    assign div_part = div_q[PART_W-1:0];

    always_comb
    begin
        div_steps    = DIV_CNT_W'(DIV_W);
        div_rem_init = '0;
        div_divisor  = period_reg;
        div_dividend = '0;
        case (cmd.div_src)
            DIV_SRC_INDEX:
            begin
                div_steps    = DIV_CNT_W'(TIDX_W);
                div_rem_init = PER_W'(idx_reg >> 1);
                div_dividend = {idx_reg[0], {PHASE_SHIFT{1'b0}}, {(DIV_W - TIDX_W){1'b0}}};
            end
            DIV_SRC_INPHASE:
            begin
                div_dividend = DIV_W'(inph_mag);
            end
            DIV_SRC_QUAD:
            begin
                div_dividend = DIV_W'(quad_mag);
            end
            DIV_SRC_POWER:
            begin
                div_divisor  = PER_W'(repeat_reg);
                div_dividend = DIV_W'(power_sum_reg);
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    qtpd_divider #(
        .PER_W(PER_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PER_W'(PERIOD_RST);
            repeat_reg    <= REP_W'(REPEAT_MAX);
            idx_reg       <= '0;
            inph_reg      <= '0;
            quad_reg      <= '0;
            power_sum_reg <= '0;
            block_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_PERIOD_LEN)
                begin
                    period_reg <= period_wr;
                end
                else
                begin
                    repeat_reg <= repeat_wr;
                end
                idx_reg       <= '0;
                inph_reg      <= '0;
                quad_reg      <= '0;
                power_sum_reg <= '0;
                block_reg     <= '0;
            end
            else
            begin
                if (cmd.acc_inph)
                begin
                    inph_reg <= inph_reg + SUM_W'(prod_reg);
                end
                if (cmd.acc_quad)
                begin
                    quad_reg <= quad_reg + SUM_W'(prod_reg);
                end
                if (cmd.step_index)
                begin
                    idx_reg <= idx_next;
                end
                if (cmd.acc_power)
                begin
                    power_sum_reg <= power_sum_reg + POW_W'(prod_bits);
                end
                if (cmd.end_block)
                begin
                    idx_reg   <= '0;
                    inph_reg  <= '0;
                    quad_reg  <= '0;
                    block_reg <= last_block ? '0 : block_reg + REP_W'(1);
                end
                if (cmd.load_result)
                begin
                    power_sum_reg <= '0;
                end
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (power_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.latch_t)
        begin
            t_reg <= div_q[TIDX_W-1:0];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.latch_re)
        begin
            re_reg <= inph_sc[MAG_W-1] ? -div_part : div_part;
        end
        if (cmd.latch_im)
        begin
            im_reg <= quad_sc[MAG_W-1] ? -div_part : div_part;
        end
        if (cmd.load_result)
        begin
            out_reg <= div_q[POWER_W-1:0];
        end
    end

    assign status.div_done    = div_done;
    assign status.last_sample = last_sample;
    assign status.last_block  = last_block;
    assign status.out_free    = !out_valid_reg || power_ready;

    assign power       = out_reg;
    assign power_valid = out_valid_reg;

    a_block_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_block |=> (idx_reg == '0) && (inph_reg == '0) && (quad_reg == '0))
        else $error("block end did not clear the correlation state");

    a_part_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.latch_re || cmd.latch_im || cmd.latch_t) |-> div_done)
        else $error("quotient taken before the divider finished");

endmodule

`default_nettype wire

/* sv/qtpd_ctrl.sv */
// ============================================================================
// Quadrature tone power detector controller
// Sequences the datapath through sample, block-end and result phases.
// ============================================================================
`default_nettype none

module qtpd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire qtpd_pkg::status_t  status,
    output qtpd_pkg::cmd_t          cmd
);
    import qtpd_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_DIV_IDX   = 13'b0000000000010,
        ST_MUL_I     = 13'b0000000000100,
        ST_MUL_Q     = 13'b0000000001000,
        ST_ACC_Q     = 13'b0000000010000,
        ST_DIV_RE    = 13'b0000000100000,
        ST_DIV_IM    = 13'b0000001000000,
        ST_SQ_RE     = 13'b0000010000000,
        ST_SQ_IM     = 13'b0000100000000,
        ST_ADD_IM    = 13'b0001000000000,
        ST_POW_START = 13'b0010000000000,
        ST_DIV_POW   = 13'b0100000000000,
        ST_EMIT      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_src     = DIV_SRC_INDEX;
                    state_next      = ST_DIV_IDX;
                end
            end
            ST_DIV_IDX:
            begin
                if (status.div_done)
                begin
                    cmd.latch_t = 1'b1;
                    state_next  = ST_MUL_I;
                end
            end
            ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_INPHASE;
                state_next  = ST_MUL_Q;
            end
            ST_MUL_Q:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = MUL_SRC_QUAD;
                cmd.acc_inph = 1'b1;
                state_next   = ST_ACC_Q;
            end
            ST_ACC_Q:
            begin
                cmd.acc_quad   = 1'b1;
                cmd.step_index = 1'b1;
                if (status.last_sample)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_SRC_INPHASE;
                    state_next    = ST_DIV_RE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_RE:
            begin
                if (status.div_done)
                begin
                    cmd.latch_re  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_SRC_QUAD;
                    state_next    = ST_DIV_IM;
                end
            end
            ST_DIV_IM:
            begin
                if (status.div_done)
                begin
                    cmd.latch_im = 1'b1;
                    state_next   = ST_SQ_RE;
                end
            end
            ST_SQ_RE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MUL_SRC_RE;
                state_next  = ST_SQ_IM;
            end
            ST_SQ_IM:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_src   = MUL_SRC_IM;
                cmd.acc_power = 1'b1;
                state_next    = ST_ADD_IM;
            end
            ST_ADD_IM:
            begin
                cmd.acc_power = 1'b1;
                cmd.end_block = 1'b1;
                state_next    = status.last_block ? ST_POW_START : ST_IDLE;
            end
            ST_POW_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DIV_SRC_POWER;
                state_next    = ST_DIV_POW;
            end
            ST_DIV_POW:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_DIV_IDX || state_reg == ST_DIV_RE ||
                             state_reg == ST_DIV_IM || state_reg == ST_DIV_POW))
        else $error("divider finished outside a wait state");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> status.out_free)
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire
